### rtl/cahc_pkg.sv
// cahc_pkg: shared types, codes and defaults of the central adaptive hop controller
package cahc_pkg;

   localparam int CAHC_HOP_SET_SIZE   = 3;
   localparam int CAHC_SPARE_SET_SIZE = 6;

   localparam int HOP_TABLE_W   = 24;
   localparam int SPARE_TABLE_W = 48;
   localparam int CHAN_W        = 8;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 48;

   // event codes
   localparam logic [2:0] EV_POLL    = 3'd0;
   localparam logic [2:0] EV_TX_OK   = 3'd1;
   localparam logic [2:0] EV_TX_FAIL = 3'd2;
   localparam logic [2:0] EV_RX      = 3'd3;
   localparam logic [2:0] EV_START   = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_INIT_HOP   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INIT_SPARE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LOSS_THR   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SYNC_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SW_LOAD    = 3'd4;

   localparam logic [7:0] LOSS_THR_RESET   = 8'd4;
   localparam logic [7:0] SYNC_LIMIT_RESET = 8'd4;
   localparam logic [7:0] SW_LOAD_RESET    = 8'd3;

   typedef struct packed {
      logic [HOP_TABLE_W-1:0]   init_hop;
      logic [SPARE_TABLE_W-1:0] init_spare;
      logic [7:0]               loss_thr;
      logic [7:0]               sync_limit;
      logic [7:0]               sw_load;
   } cfg_type;

   typedef struct packed {
      logic                   poll_send;
      logic                   poll_peripheral;
      logic [7:0]             poll_switch_count;
      logic [HOP_TABLE_W-1:0] poll_table;
      logic                   flush_tx;
      logic                   set_channel;
      logic [CHAN_W-1:0]      new_channel;
      logic                   rx_report;
   } rsp_type;

endpackage

### rtl/central_adaptive_hop_controller_core.sv
// central_adaptive_hop_controller_core: top level with config registers and result buffer
//
// Central side of an adaptive hop poll scheme for two peripherals. The hop state updates at
// the edge that accepts an event word, and the result word is registered into the result
// buffer at that edge. One event word can be taken every clock while the buffer has room; a
// two-entry result buffer keeps req_ready high while one result waits, so req_ready
// drops only when two results are unread. Configuration writes are taken every cycle
// and act on the next start event or poll.
module central_adaptive_hop_controller_core import cahc_pkg::*; #(
   parameter int HOP_SET_SIZE   = CAHC_HOP_SET_SIZE,
   parameter int SPARE_SET_SIZE = CAHC_SPARE_SET_SIZE
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_event_req,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_poll_send,
   output logic                     rsp_poll_peripheral,
   output logic [7:0]               rsp_poll_switch_count,
   output logic [HOP_TABLE_W-1:0]   rsp_poll_table,
   output logic                     rsp_flush_tx,
   output logic                     rsp_set_channel,
   output logic [CHAN_W-1:0]        rsp_new_channel,
   output logic                     rsp_rx_report,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   cfg_type    cfg_ff, cfg_in;
   rsp_type    step_rsp;
   rsp_type    head_ff, head_in;
   rsp_type    tail_ff, tail_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_INIT_HOP:   cfg_in.init_hop   = csr_data[HOP_TABLE_W-1:0];
            REG_INIT_SPARE: cfg_in.init_spare = csr_data[SPARE_TABLE_W-1:0];
            REG_LOSS_THR:   cfg_in.loss_thr   = csr_data[7:0];
            REG_SYNC_LIMIT: cfg_in.sync_limit = csr_data[7:0];
            REG_SW_LOAD:    cfg_in.sw_load    = csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.init_hop   <= '0;
         cfg_ff.init_spare <= '0;
         cfg_ff.loss_thr   <= LOSS_THR_RESET;
         cfg_ff.sync_limit <= SYNC_LIMIT_RESET;
         cfg_ff.sw_load    <= SW_LOAD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cahc_engine #(
      .HOP_SET_SIZE   (HOP_SET_SIZE),
      .SPARE_SET_SIZE (SPARE_SET_SIZE)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .ev_accept (push),
      .ev_code   (req_event_req),
      .cfg       (cfg_ff),
      .result    (step_rsp)
   );

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;

   // two-word result buffer, head drives the outputs
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      if (push && (count_ff == 2'd0 || (count_ff == 2'd1 && pop))) begin
         head_in = step_rsp;
      end else if (pop && count_ff == 2'd2) begin
         head_in = tail_ff;
      end
      if (push && count_ff == 2'd1 && !pop) begin
         tail_in = step_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_poll_send         = head_ff.poll_send;
   assign rsp_poll_peripheral   = head_ff.poll_peripheral;
   assign rsp_poll_switch_count = head_ff.poll_switch_count;
   assign rsp_poll_table        = head_ff.poll_table;
   assign rsp_flush_tx          = head_ff.flush_tx;
   assign rsp_set_channel       = head_ff.set_channel;
   assign rsp_new_channel       = head_ff.new_channel;
   assign rsp_rx_report         = head_ff.rx_report;

endmodule

### rtl/cahc_engine.sv
// cahc_engine: hop state registers and the per-event update and result logic
module cahc_engine import cahc_pkg::*; #(
   parameter int HOP_SET_SIZE   = CAHC_HOP_SET_SIZE,
   parameter int SPARE_SET_SIZE = CAHC_SPARE_SET_SIZE
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        ev_accept,
   input  logic [2:0]  ev_code,
   input  cfg_type     cfg,
   output rsp_type     result
);

   localparam int HP_W = $clog2(HOP_SET_SIZE);

   logic [CHAN_W-1:0] hop_ff   [HOP_SET_SIZE];
   logic [CHAN_W-1:0] hop_in   [HOP_SET_SIZE];
   logic [CHAN_W-1:0] next_ff  [HOP_SET_SIZE];
   logic [CHAN_W-1:0] next_in  [HOP_SET_SIZE];
   logic [CHAN_W-1:0] spare_ff [SPARE_SET_SIZE];
   logic [CHAN_W-1:0] spare_in [SPARE_SET_SIZE];
   logic [7:0]        loss_ff  [HOP_SET_SIZE];
   logic [7:0]        loss_in  [HOP_SET_SIZE];
   logic [7:0]        cd_ff    [2];
   logic [7:0]        cd_in    [2];
   logic [7:0]        miss_ff  [2];
   logic [7:0]        miss_in  [2];
   logic [1:0]        sync_ff, sync_in;
   logic [1:0]        rs_ff, rs_in;
   logic              pend_ff, pend_in;
   logic              per_ff, per_in;
   logic [HP_W-1:0]   hp_ff, hp_in;

   always_comb begin
      logic              p;
      logic              adv;
      logic              rc;
      logic [CHAN_W-1:0] removed;
      hop_in   = hop_ff;
      next_in  = next_ff;
      spare_in = spare_ff;
      loss_in  = loss_ff;
      cd_in    = cd_ff;
      miss_in  = miss_ff;
      sync_in  = sync_ff;
      rs_in    = rs_ff;
      pend_in  = pend_ff;
      per_in   = per_ff;
      hp_in    = hp_ff;
      result   = '0;
      p        = per_ff;
      adv      = 1'b0;
      rc       = 1'b0;
      removed  = '0;
      unique case (ev_code)
         EV_START: begin
            for (int i = 0; i < HOP_SET_SIZE; i++) begin
               hop_in[i]  = cfg.init_hop[8*i +: 8];
               next_in[i] = cfg.init_hop[8*i +: 8];
            end
            for (int i = 0; i < SPARE_SET_SIZE; i++) begin
               spare_in[i] = cfg.init_spare[8*i +: 8];
            end
            result.set_channel = 1'b1;
            result.new_channel = hop_in[hp_ff];
         end
         EV_POLL: begin
            result.flush_tx = 1'b1;
            if (miss_ff[p] != 8'hff) begin
               miss_in[p] = miss_ff[p] + 8'd1;
            end
            if (miss_in[p] >= cfg.sync_limit) begin
               sync_in[p] = 1'b0;
            end
            result.poll_send         = 1'b1;
            result.poll_peripheral   = p;
            result.poll_switch_count = cd_ff[p];
            for (int i = 0; i < HOP_SET_SIZE; i++) begin
               result.poll_table[8*i +: 8] = next_ff[i];
            end
            if (pend_ff) begin
               if (sync_in[p] && loss_ff[hp_ff] != 8'hff) begin
                  loss_in[hp_ff] = loss_ff[hp_ff] + 8'd1;
               end
               if (cd_ff[p] != 8'd0) begin
                  cd_in[p] = cd_ff[p] - 8'd1;
               end else begin
                  hop_in = next_ff;
               end
               // hop channel lost too often: swap in the first spare
               if (loss_in[hp_ff] >= cfg.loss_thr) begin
                  removed = hop_in[hp_ff];
                  for (int i = 0; i < HOP_SET_SIZE; i++) begin
                     loss_in[i] = 8'd0;
                  end
                  pend_in        = 1'b0;
                  next_in[hp_ff] = spare_ff[0];
                  for (int i = 0; i + 1 < SPARE_SET_SIZE; i++) begin
                     spare_in[i] = spare_ff[i+1];
                  end
                  spare_in[SPARE_SET_SIZE-1] = removed;
                  cd_in[0] = cfg.sw_load;
                  cd_in[1] = cfg.sw_load;
               end
            end
         end
         EV_TX_FAIL: begin
            result.flush_tx = 1'b1;
            adv             = 1'b1;
         end
         EV_RX: begin
            sync_in[p] = 1'b1;
            rs_in[p]   = 1'b1;
            miss_in[p] = 8'd0;
            rc = (!sync_in[0] || rs_in[0]) && (!sync_in[1] || rs_in[1]);
            if (p && rc) begin
               loss_in[hp_ff] = 8'd0;
            end
            cd_in[p]         = 8'd0;
            pend_in          = 1'b1;
            result.rx_report = 1'b1;
            adv              = 1'b1;
         end
         default: begin
         end
      endcase

      if (adv) begin
         per_in = ~p;
         if (p) begin
            // back to peripheral 0: next hop
            hp_in = (hp_ff == HP_W'(HOP_SET_SIZE - 1)) ? '0 : hp_ff + HP_W'(1);
            result.set_channel = 1'b1;
            result.new_channel = hop_in[hp_in];
         end else begin
            rc = (!sync_in[0] || rs_in[0]) && (!sync_in[1] || rs_in[1]);
            if (rc) begin
               loss_in[hp_ff] = 8'd0;
               rs_in          = 2'b00;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HOP_SET_SIZE; i++) begin
            hop_ff[i]  <= '0;
            next_ff[i] <= '0;
            loss_ff[i] <= '0;
         end
         for (int i = 0; i < SPARE_SET_SIZE; i++) begin
            spare_ff[i] <= '0;
         end
         cd_ff[0]   <= '0;
         cd_ff[1]   <= '0;
         miss_ff[0] <= '0;
         miss_ff[1] <= '0;
         sync_ff    <= '0;
         rs_ff      <= '0;
         pend_ff    <= 1'b0;
         per_ff     <= 1'b0;
         hp_ff      <= '0;
      end else if (ev_accept) begin
         hop_ff   <= hop_in;
         next_ff  <= next_in;
         spare_ff <= spare_in;
         loss_ff  <= loss_in;
         cd_ff    <= cd_in;
         miss_ff  <= miss_in;
         sync_ff  <= sync_in;
         rs_ff    <= rs_in;
         pend_ff  <= pend_in;
         per_ff   <= per_in;
         hp_ff    <= hp_in;
      end
   end

endmodule

### rtl/cahc_checker.sv
// cahc_checker: port-level assertions for the hop controller, bound to the top level
module cahc_checker import cahc_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_poll_send,
   input logic                   rsp_poll_peripheral,
   input logic [7:0]             rsp_poll_switch_count,
   input logic [HOP_TABLE_W-1:0] rsp_poll_table,
   input logic                   rsp_flush_tx,
   input logic                   rsp_set_channel,
   input logic [CHAN_W-1:0]      rsp_new_channel,
   input logic                   rsp_rx_report
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_poll_table)
         && $stable(rsp_new_channel) && $stable(rsp_poll_switch_count))
      else $error("stalled result word changed");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid ##1 rsp_valid |-> $past(req_valid && req_ready))
      else $error("result word without an accepted event word");

   a_poll_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_poll_send |-> !rsp_poll_peripheral
         && rsp_poll_switch_count == 8'd0 && rsp_poll_table == '0)
      else $error("poll fields set without a poll");

   a_poll_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_set_channel || rsp_new_channel == '0)
         && !(rsp_poll_send && (rsp_rx_report || rsp_set_channel))
         && (!rsp_poll_send || rsp_flush_tx))
      else $error("inconsistent result word");

endmodule

bind central_adaptive_hop_controller_core cahc_checker u_cahc_checker (.*);

### tb/tb_central_adaptive_hop_controller_core.sv
// self-checking testbench for the central adaptive hop controller core
module tb_central_adaptive_hop_controller_core;
   import cahc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;

   // event codes the block ignores
   localparam logic [2:0] EV_RSVD5 = 3'd5;
   localparam logic [2:0] EV_RSVD6 = 3'd6;
   localparam logic [2:0] EV_RSVD7 = 3'd7;

   class hop_scoreboard;
      logic [HOP_TABLE_W-1:0]   init_hop;
      logic [SPARE_TABLE_W-1:0] init_spare;
      logic [7:0] loss_thr;
      logic [7:0] sync_lim;
      logic [7:0] sw_load;

      logic [7:0] hop_set  [CAHC_HOP_SET_SIZE];
      logic [7:0] next_set [CAHC_HOP_SET_SIZE];
      logic [7:0] spare    [CAHC_SPARE_SET_SIZE];
      logic [7:0] loss     [CAHC_HOP_SET_SIZE];
      logic [7:0] sw_cnt   [2];
      logic [7:0] miss     [2];
      bit         in_sync  [2];
      bit         round_ok [2];
      bit         upd_pending;
      bit         cur_p;
      int         hop_pos;

      rsp_type    expected_q[$];
      int         errors;

      function new();
         init_hop   = '0;
         init_spare = '0;
         loss_thr   = LOSS_THR_RESET;
         sync_lim   = SYNC_LIMIT_RESET;
         sw_load    = SW_LOAD_RESET;
         foreach (hop_set[i]) begin
            hop_set[i]  = '0;
            next_set[i] = '0;
            loss[i]     = '0;
         end
         foreach (spare[i]) spare[i] = '0;
         for (int i = 0; i < 2; i++) begin
            sw_cnt[i]   = '0;
            miss[i]     = '0;
            in_sync[i]  = 0;
            round_ok[i] = 0;
         end
         upd_pending = 0;
         cur_p       = 0;
         hop_pos     = 0;
         errors      = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
         case (idx)
            REG_INIT_HOP:   init_hop   = d[HOP_TABLE_W-1:0];
            REG_INIT_SPARE: init_spare = d[SPARE_TABLE_W-1:0];
            REG_LOSS_THR:   loss_thr   = d[7:0];
            REG_SYNC_LIMIT: sync_lim   = d[7:0];
            REG_SW_LOAD:    sw_load    = d[7:0];
            default: ;
         endcase
      endfunction

      function bit round_done();
         return (!in_sync[0] || round_ok[0]) && (!in_sync[1] || round_ok[1]);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_event(logic [2:0] ev);
         rsp_type    r;
         bit         p;
         bit         adv;
         logic [7:0] removed;
         r   = '0;
         p   = cur_p;
         adv = 0;
         if (hop_pos >= CAHC_HOP_SET_SIZE) hop_pos = 0;
         case (ev)
            EV_START: begin
               for (int i = 0; i < CAHC_HOP_SET_SIZE; i++) begin
                  hop_set[i]  = init_hop[8*i +: 8];
                  next_set[i] = hop_set[i];
               end
               for (int i = 0; i < CAHC_SPARE_SET_SIZE; i++) spare[i] = init_spare[8*i +: 8];
               r.set_channel = 1;
               r.new_channel = hop_set[hop_pos];
            end
            EV_POLL: begin
               r.flush_tx = 1;
               if (miss[p] != 8'hFF) miss[p]++;
               if (miss[p] >= sync_lim) in_sync[p] = 0;
               r.poll_send         = 1;
               r.poll_peripheral   = p;
               r.poll_switch_count = sw_cnt[p];
               for (int i = 0; i < CAHC_HOP_SET_SIZE; i++) r.poll_table[8*i +: 8] = next_set[i];
               if (upd_pending) begin
                  if (in_sync[p] && loss[hop_pos] != 8'hFF) loss[hop_pos]++;
                  if (sw_cnt[p] != 0) sw_cnt[p]--;
                  else hop_set = next_set;
                  if (loss[hop_pos] >= loss_thr) begin
                     // swap in the first spare, the dropped channel goes to the tail
                     removed = hop_set[hop_pos];
                     foreach (loss[i]) loss[i] = '0;
                     upd_pending = 0;
                     next_set[hop_pos] = spare[0];
                     for (int i = 0; i + 1 < CAHC_SPARE_SET_SIZE; i++) spare[i] = spare[i+1];
                     spare[CAHC_SPARE_SET_SIZE-1] = removed;
                     sw_cnt[0] = sw_load;
                     sw_cnt[1] = sw_load;
                  end
               end
            end
            EV_TX_FAIL: begin
               r.flush_tx = 1;
               adv = 1;
            end
            EV_RX: begin
               in_sync[p]  = 1;
               round_ok[p] = 1;
               miss[p]     = '0;
               if (p && round_done()) loss[hop_pos] = '0;
               sw_cnt[p]   = '0;
               upd_pending = 1;
               r.rx_report = 1;
               adv = 1;
            end
            default: ;
         endcase
         if (adv) begin
            p = !p;
            cur_p = p;
            if (!p) begin
               hop_pos = (hop_pos + 1) % CAHC_HOP_SET_SIZE;
               r.set_channel = 1;
               r.new_channel = hop_set[hop_pos];
            end else if (round_done()) begin
               loss[hop_pos] = '0;
               round_ok[0]   = 0;
               round_ok[1]   = 0;
            end
         end
         expected_q.push_back(r);
      endfunction

      function void cmp_field(string name, logic [31:0] e, logic [31:0] a);
         if (e !== a) begin
            $error("%s expected %0h actual %0h", name, e, a);
            errors++;
         end
      endfunction

      function void check_result(rsp_type act);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
            return;
         end
         e = expected_q.pop_front();
         cmp_field("poll_send", e.poll_send, act.poll_send);
         cmp_field("poll_peripheral", e.poll_peripheral, act.poll_peripheral);
         cmp_field("poll_switch_count", e.poll_switch_count, act.poll_switch_count);
         cmp_field("poll_table", e.poll_table, act.poll_table);
         cmp_field("flush_tx", e.flush_tx, act.flush_tx);
         cmp_field("set_channel", e.set_channel, act.set_channel);
         cmp_field("new_channel", e.new_channel, act.new_channel);
         cmp_field("rx_report", e.rx_report, act.rx_report);
      endfunction
   endclass

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_valid = 0;
   logic                     req_ready;
   logic [2:0]               req_event_req = EV_POLL;
   logic                     rsp_valid;
   logic                     rsp_ready = 0;
   logic                     rsp_poll_send;
   logic                     rsp_poll_peripheral;
   logic [7:0]               rsp_poll_switch_count;
   logic [HOP_TABLE_W-1:0]   rsp_poll_table;
   logic                     rsp_flush_tx;
   logic                     rsp_set_channel;
   logic [CHAN_W-1:0]        rsp_new_channel;
   logic                     rsp_rx_report;
   logic                     csr_valid = 0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = REG_INIT_HOP;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   hop_scoreboard sb;
   int send_idle   = 0;
   int recv_stall  = 0;
   int hold_start  = 0;
   int hold_left   = 0;
   int cycle_count = 0;

   central_adaptive_hop_controller_core uut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("central_adaptive_hop_controller_core verification failed");
         $finish;
      end
   end

   // receiver side, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_start != 0) begin
         hold_left  = HOLD_CYCLES;
         hold_start = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   always @(posedge clock) begin
      if (!reset && sb != null) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_valid && req_ready) sb.note_event(req_event_req);
         if (rsp_valid && rsp_ready)
            sb.check_result({rsp_poll_send, rsp_poll_peripheral, rsp_poll_switch_count,
                             rsp_poll_table, rsp_flush_tx, rsp_set_channel,
                             rsp_new_channel, rsp_rx_report});
      end
   end

   task automatic send_event(logic [2:0] ev);
      req_valid     <= 1;
      req_event_req <= ev;
      do @(posedge clock); while (!req_ready);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
   endtask

   // drop valid and wait until every result word has come back
   task automatic finish_phase();
      req_valid <= 0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic load_settings(logic [HOP_TABLE_W-1:0] hop, logic [SPARE_TABLE_W-1:0] spr,
                                logic [7:0] thr, logic [7:0] lim, logic [7:0] load);
      logic [CSR_INDEX_W-1:0] idx_l [6];
      logic [CSR_DATA_W-1:0]  dat_l [6];
      idx_l[0] = REG_INIT_HOP;   dat_l[0] = {24'($urandom), hop};
      idx_l[1] = REG_INIT_SPARE; dat_l[1] = spr;
      idx_l[2] = REG_LOSS_THR;   dat_l[2] = {40'({$urandom, $urandom}), thr};
      // unused index, must leave everything alone
      idx_l[3] = CSR_INDEX_W'($urandom_range(5, 7));
      dat_l[3] = CSR_DATA_W'({$urandom, $urandom});
      idx_l[4] = REG_SYNC_LIMIT; dat_l[4] = CSR_DATA_W'(lim);
      idx_l[5] = REG_SW_LOAD;    dat_l[5] = CSR_DATA_W'(load);
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1;
         csr_index <= idx_l[i];
         csr_data  <= dat_l[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 0;
   endtask

   // mostly poll bursts closed by an answer or a failure, some noise
   task automatic run_random(int n);
      int count;
      int k;
      logic [2:0] ev;
      count = 0;
      while (count < n) begin
         if ($urandom_range(99) < 80) begin
            if ($urandom_range(99) < 4) begin
               send_event(EV_START);
               count++;
            end
            k = $urandom_range(0, 8);
            repeat (k) send_event(EV_POLL);
            send_event(($urandom_range(99) < 70) ? EV_RX : EV_TX_FAIL);
            count += k + 1;
         end else begin
            ev = 3'($urandom_range(7));
            send_event(ev);
            if (ev != EV_TX_OK && ev < EV_RSVD5) count++;
         end
      end
   endtask

   task automatic rand_tables_phase(logic [7:0] thr, logic [7:0] lim, logic [7:0] load,
                                    int s_idle, int r_stall, int n);
      load_settings(HOP_TABLE_W'($urandom), SPARE_TABLE_W'({$urandom, $urandom}),
                    thr, lim, load);
      send_idle  = s_idle;
      recv_stall = r_stall;
      send_event(EV_START);
      run_random(n);
      finish_phase();
   endtask

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset settings: poll on zero tables, ignored codes, tx success
      send_event(EV_POLL);
      send_event(EV_TX_OK);
      send_event(EV_RSVD5);
      send_event(EV_RSVD6);
      send_event(EV_RSVD7);
      send_event(EV_RX);
      send_event(EV_POLL);
      send_event(EV_TX_FAIL);
      send_event(EV_POLL);
      send_event(EV_TX_FAIL);
      finish_phase();

      load_settings(24'h00FF7F, 48'hFF00_0102_03FE, 8'd1, 8'd255, 8'd255);
      send_event(EV_START);
      send_event(EV_RX);
      send_event(EV_POLL);
      send_event(EV_POLL);
      send_event(EV_RX);
      send_event(EV_POLL);
      send_event(EV_TX_FAIL);
      send_event(EV_RX);
      send_event(EV_POLL);
      send_event(EV_TX_FAIL);
      send_event(EV_START);
      finish_phase();

      rand_tables_phase(LOSS_THR_RESET, SYNC_LIMIT_RESET, SW_LOAD_RESET, 0, 0, 150);
      rand_tables_phase(8'd1, 8'd255, 8'd0, 74, 0, 150);
      rand_tables_phase(8'd255, 8'd1, 8'd255, 0, 74, 120);

      // long receiver hold-off so the block backs up its input
      hold_start = 1;
      rand_tables_phase(8'd2, 8'd6, 8'd1, 22, 22, 200);

      // zero threshold and zero sync limit
      rand_tables_phase(8'd0, 8'd0, 8'd0, 0, 0, 80);

      // long run of unanswered polls to saturate the miss counter
      load_settings(HOP_TABLE_W'($urandom), SPARE_TABLE_W'({$urandom, $urandom}),
                    8'd255, 8'd255, 8'd255);
      send_idle  = 0;
      recv_stall = 0;
      send_event(EV_START);
      send_event(EV_RX);
      send_event(EV_RX);
      repeat (300) send_event(EV_POLL);
      send_event(EV_TX_FAIL);
      send_event(EV_RX);
      finish_phase();

      rand_tables_phase(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                        8'($urandom_range(255)), 22, 22, 150);

      if (sb.errors == 0)
         $display("central_adaptive_hop_controller_core verification clean");
      else
         $display("central_adaptive_hop_controller_core verification failed");
      $finish;
   end

endmodule
